@@ hw/rtl/tpd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants for the thermistor PID drive block.
// ----------------------------------------------------------------------------
package tpd_pkg;

	localparam int DIV_W   = 44;
	localparam int DVS_W   = 12;
	localparam int PTS_N   = 33;
	localparam int SCAN_MAX = 32;

	localparam logic [22:0] PCT_MAX   = 23'd6553600;
	localparam logic [22:0] PCT_HALF  = 23'd3276800;
	localparam logic [7:0]  DRIVE_LIM = 8'd220;
	localparam logic [4:0]  STEP_DIVISOR = 5'd25;
	localparam logic [16:0] RECIP_25  = 17'd83887;
	localparam logic [5:0]  DV25_STEP = 6'd11;
	localparam logic signed [6:0] ZERO_ENTRY = 7'sd10;
	localparam logic signed [15:0] DEG_STEP  = 16'sd500;
	localparam logic [12:0] RECIP_100 = 13'd5243;

	localparam logic [1:0] REG_KP     = 2'd0;
	localparam logic [1:0] REG_KI     = 2'd1;
	localparam logic [1:0] REG_KD     = 2'd2;
	localparam logic [1:0] REG_TARGET = 2'd3;

	localparam logic signed [15:0] TEMP_PTS [PTS_N] = '{
		-16'sd14313, -16'sd12734, -16'sd11189, -16'sd9676, -16'sd8203,
		-16'sd6761,  -16'sd5348,  -16'sd3970,  -16'sd2614, -16'sd1297,
		16'sd0,      16'sd1266,   16'sd2507,   16'sd3725,  16'sd4914,
		16'sd6081,   16'sd7226,   16'sd8351,   16'sd9450,  16'sd10529,
		16'sd11590,  16'sd12626,  16'sd13645,  16'sd14646, 16'sd15626,
		16'sd16589,  16'sd17536,  16'sd18467,  16'sd19379, 16'sd20276,
		16'sd21158,  16'sd22023,  16'sd22878
	};

	typedef enum logic [4:0] {
		OP_NOP,
		OP_CAPT,
		OP_SCAN,
		OP_MISS,
		OP_MULJ,
		OP_SUM,
		OP_NUM,
		OP_DIV,
		OP_TEMP,
		OP_ERR,
		OP_MULP,
		OP_MULI,
		OP_MULD,
		OP_LDS,
		OP_DV25,
		OP_PCT,
		OP_DRV
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic found;
		logic div_done;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MULJ,
		ST_SUM,
		ST_NUM,
		ST_DIVT,
		ST_TEMP,
		ST_ERR,
		ST_MULP,
		ST_MULI,
		ST_MULD,
		ST_LDS,
		ST_DIVS,
		ST_PCT,
		ST_DRV,
		ST_OUT
	} ctrl_state_t;

endpackage

@@ hw/rtl/tpd_datapath.sv @@
// ----------------------------------------------------------------------------
// tpd_datapath
// Table scan, shared multiplier, iterative divider, PID state and result regs.
// ----------------------------------------------------------------------------
module tpd_datapath import tpd_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic signed [15:0] adc_sample,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic [7:0]         motor_drive,
	output logic               drive_high,
	output logic signed [15:0] temperature
);

	localparam int SCAN_N = (TABLE_ENTRIES > SCAN_MAX) ? SCAN_MAX : TABLE_ENTRIES;

	logic signed [15:0] kp_q, ki_q, kd_q, target_q;
	logic signed [15:0] c_q;
	logic [4:0]         idx_q, j_q;
	logic               found_q;
	logic signed [19:0] p_q, s_q;
	logic [DIV_W-1:0]   dq_q;
	logic [DVS_W-1:0]   rem_q, dvs_q;
	logic [5:0]         dcnt_q;
	logic               dneg_q;
	logic signed [15:0] last_temp_q;
	logic signed [16:0] e_q, e1_q, e2_q;
	logic signed [17:0] de1_q;
	logic signed [18:0] dd_q;
	logic signed [37:0] acc_q;
	logic [22:0]        pct_q;
	logic [14:0]        y_q;

	logic signed [15:0] tj, tj1, d16;
	logic signed [6:0]  jm;
	logic signed [19:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [35:0] mul_p;
	logic [DIV_W-1:0]   num_mag, s_mag;
	logic signed [43:0] n_s;
	logic [DVS_W-1:0]   rem_sh;
	logic               ge;
	logic [15:0]        x25;
	logic [32:0]        x25_m;
	logic [10:0]        q25;
	logic [15:0]        r25;
	logic signed [15:0] q16;
	logic signed [16:0] e_new;
	logic signed [45:0] inc, r;
	logic [30:0]        x255;
	logic [27:0]        y_m;

	assign tj    = TEMP_PTS[j_q];
	assign tj1   = TEMP_PTS[6'(j_q) + 6'd1];
	assign d16   = tj1 - tj;
	assign jm    = $signed({2'b00, j_q}) - ZERO_ENTRY;
	assign e_new = 17'(last_temp_q) - 17'(target_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MULJ: begin
				mul_a = 20'(jm);
				mul_b = d16;
			end
			OP_NUM: begin
				mul_a = s_q;
				mul_b = DEG_STEP;
			end
			OP_MULP: begin
				mul_a = 20'(de1_q);
				mul_b = kp_q;
			end
			OP_MULI: begin
				mul_a = 20'(e_q);
				mul_b = ki_q;
			end
			OP_MULD: begin
				mul_a = 20'(dd_q);
				mul_b = kd_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign num_mag = mul_p[35] ? DIV_W'(-mul_p) : DIV_W'(mul_p);
	assign n_s     = {acc_q, 6'b0};
	assign s_mag   = n_s[43] ? DIV_W'(-n_s) : DIV_W'(n_s);
	assign rem_sh  = {rem_q[DVS_W-2:0], dq_q[DIV_W-1]};
	assign ge      = (rem_sh >= dvs_q);
	assign x25     = {rem_q[4:0], dq_q[DIV_W-1 -: 11]};
	assign x25_m   = x25 * RECIP_25;
	assign q25     = x25_m[31:21];
	assign r25     = x25 - 16'(q25) * 16'(STEP_DIVISOR);
	assign q16     = dneg_q ? -$signed(dq_q[15:0]) : $signed(dq_q[15:0]);
	assign inc     = dneg_q ? -$signed({2'b00, dq_q}) - 46'(rem_q != '0)
	                        : $signed({2'b00, dq_q});
	assign r       = $signed({23'b0, pct_q}) + inc;
	assign x255    = pct_q * 8'd255;
	assign y_m     = y_q * RECIP_100;

	assign stat.scan_last = (idx_q == 5'(SCAN_N - 1));
	assign stat.found     = found_q;
	assign stat.div_done  = (dcnt_q == 6'(DIV_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			target_q    <= '0;
			last_temp_q <= '0;
			e1_q        <= '0;
			e2_q        <= '0;
			pct_q       <= PCT_HALF;
			found_q     <= 1'b0;
			idx_q       <= '0;
			dcnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KP:     kp_q     <= cfg_data;
					REG_KI:     ki_q     <= cfg_data;
					REG_KD:     kd_q     <= cfg_data;
					REG_TARGET: target_q <= cfg_data;
					default:    kp_q     <= kp_q;
				endcase
			end
			case (cmd.op)
				OP_CAPT: begin
					idx_q   <= '0;
					found_q <= 1'b0;
				end
				OP_SCAN: begin
					if (TEMP_PTS[idx_q] <= c_q) begin
						found_q <= 1'b1;
					end
					idx_q <= idx_q + 5'd1;
				end
				OP_MISS: last_temp_q <= -16'sd1;
				OP_NUM:  dcnt_q      <= '0;
				OP_LDS:  dcnt_q      <= '0;
				OP_DIV:  dcnt_q      <= dcnt_q + 6'd1;
				OP_DV25: dcnt_q      <= dcnt_q + DV25_STEP;
				OP_TEMP: last_temp_q <= q16;
				OP_PCT: begin
					e2_q <= e1_q;
					e1_q <= e_q;
					if (r > $signed({23'b0, PCT_MAX})) begin
						pct_q <= PCT_MAX;
					end else if (r < 0) begin
						pct_q <= '0;
					end else begin
						pct_q <= r[22:0];
					end
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPT: c_q <= adc_sample;
			OP_SCAN: begin
				if (TEMP_PTS[idx_q] <= c_q) begin
					j_q <= idx_q;
				end
			end
			OP_MULJ: p_q <= mul_p[19:0];
			OP_SUM:  s_q <= p_q + 20'(c_q) - 20'(tj);
			OP_NUM: begin
				dq_q   <= num_mag;
				rem_q  <= '0;
				dvs_q  <= DVS_W'(d16);
				dneg_q <= mul_p[35];
			end
			OP_DIV: begin
				rem_q <= ge ? rem_sh - dvs_q : rem_sh;
				dq_q  <= {dq_q[DIV_W-2:0], ge};
			end
			OP_ERR: begin
				e_q   <= e_new;
				de1_q <= 18'(e_new) - 18'(e1_q);
				dd_q  <= 19'(e_new) - (19'(e1_q) <<< 1) + 19'(e2_q);
			end
			OP_MULP: acc_q <= 38'(mul_p);
			OP_MULI: acc_q <= acc_q + 38'(mul_p);
			OP_MULD: acc_q <= acc_q + 38'(mul_p);
			OP_LDS: begin
				dq_q   <= s_mag;
				rem_q  <= '0;
				dneg_q <= n_s[43];
			end
			OP_DV25: begin
				rem_q <= DVS_W'(r25);
				dq_q  <= {dq_q[DIV_W-12:0], q25};
			end
			OP_DRV:  y_q <= x255[30:16];
			default: c_q <= c_q;
		endcase
		if (cmd.load_out) begin
			motor_drive <= y_m[26:19];
			drive_high  <= (y_m[26:19] > DRIVE_LIM);
			temperature <= last_temp_q;
		end
	end

endmodule

@@ hw/rtl/tpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpd_ctrl
// Sequencer for conversion, PID update and result handoff.
// ----------------------------------------------------------------------------
module tpd_ctrl import tpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     sample_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NOP;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPT;
					state_d = sample_valid ? ST_SCAN : ST_ERR;
				end
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN;
				if (stat.scan_last) begin
					state_d = ST_MULJ;
				end
			end
			ST_MULJ: begin
				if (stat.found) begin
					cmd.op  = OP_MULJ;
					state_d = ST_SUM;
				end else begin
					cmd.op  = OP_MISS;
					state_d = ST_ERR;
				end
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_NUM;
			end
			ST_NUM: begin
				cmd.op  = OP_NUM;
				state_d = ST_DIVT;
			end
			ST_DIVT: begin
				if (stat.div_done) begin
					state_d = ST_TEMP;
				end else begin
					cmd.op = OP_DIV;
				end
			end
			ST_TEMP: begin
				cmd.op  = OP_TEMP;
				state_d = ST_ERR;
			end
			ST_ERR: begin
				cmd.op  = OP_ERR;
				state_d = ST_MULP;
			end
			ST_MULP: begin
				cmd.op  = OP_MULP;
				state_d = ST_MULI;
			end
			ST_MULI: begin
				cmd.op  = OP_MULI;
				state_d = ST_MULD;
			end
			ST_MULD: begin
				cmd.op  = OP_MULD;
				state_d = ST_LDS;
			end
			ST_LDS: begin
				cmd.op  = OP_LDS;
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				if (stat.div_done) begin
					state_d = ST_PCT;
				end else begin
					cmd.op = OP_DV25;
				end
			end
			ST_PCT: begin
				cmd.op  = OP_PCT;
				state_d = ST_DRV;
			end
			ST_DRV: begin
				cmd.op  = OP_DRV;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/thermistor_pid_drive_top.sv @@
// ----------------------------------------------------------------------------
// thermistor_pid_drive_top
// Thermistor sample to temperature, incremental PID, motor drive byte.
//
//   beat     signals                               direction
//   input    in_valid/in_stall, adc_sample,        in
//            sample_valid
//   result   out_valid/out_stall, motor_drive,     out
//            drive_high, temperature
//   config   cfg_we, cfg_index, cfg_data           in
//
// A valid sample goes from its input beat to the result load through a capture,
// a 32-entry table scan at one entry per cycle, a 44-step restoring divide for
// the interpolation and a 4-step radix-2048 divide by 25 for the PID increment.
// Below-table samples skip the interpolation; invalid ones skip the scan too.
// Input stalls until the result loads; the next beat is taken in the cycle after.
// Reset gives zero gains, zero setpoint and 50 percent drive. A stalled result
// holds the result stage; the next beat is still taken and waits at the end.
// ----------------------------------------------------------------------------
module thermistor_pid_drive_top import tpd_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] adc_sample,
	input  logic               sample_valid,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         motor_drive,
	output logic               drive_high,
	output logic signed [15:0] temperature
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.sample_valid (sample_valid),
		.in_stall     (in_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	tpd_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.adc_sample  (adc_sample),
		.cmd         (cmd),
		.stat        (stat),
		.motor_drive (motor_drive),
		.drive_high  (drive_high),
		.temperature (temperature)
	);

endmodule
